// ----- src/ccc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the calendar clock counter.
// No dependencies; every module of the block imports this package.
package ccc_pkg;

  // Field widths of the payload words
  localparam int YEAR_OUT_W  = 14;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;
  localparam int HOUR_W      = 5;
  localparam int MINUTE_W    = 6;
  localparam int SECOND_W    = 6;
  localparam int MILLI_W     = 10;
  localparam int TICK_W      = 32;
  localparam int ELAPSED_W   = 12;
  // Milliseconds plus one advance: at most 999 + 4095
  localparam int TOTAL_W     = 13;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 14;

  localparam logic [CFG_INDEX_W-1:0] CFG_PRESET_YEAR   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRESET_MONTH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRESET_DAY    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRESET_HOUR   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRESET_MINUTE = 3'd4;

  // Reset values of the preset registers
  localparam logic [YEAR_OUT_W-1:0] RST_PRESET_YEAR   = 14'd2241;
  localparam logic [MONTH_W-1:0]    RST_PRESET_MONTH  = 4'd1;
  localparam logic [DAY_W-1:0]      RST_PRESET_DAY    = 5'd1;
  localparam logic [HOUR_W-1:0]     RST_PRESET_HOUR   = 5'd0;
  localparam logic [MINUTE_W-1:0]   RST_PRESET_MINUTE = 6'd0;

  // Commands
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Calendar constants
  localparam logic [TOTAL_W-1:0]  MS_PER_SEC    = 13'd1000;
  localparam logic [6:0]          SEC_PER_MIN   = 7'd60;
  localparam logic [6:0]          MIN_PER_HOUR  = 7'd60;
  localparam logic [5:0]          HOUR_PER_DAY  = 6'd24;
  localparam logic [MONTH_W-1:0]  MONTH_LAST    = 4'd12;
  localparam logic [MONTH_W-1:0]  MONTH_FEB     = 4'd2;
  localparam logic [MONTH_W-1:0]  MONTH_APR     = 4'd4;
  localparam logic [MONTH_W-1:0]  MONTH_JUN     = 4'd6;
  localparam logic [MONTH_W-1:0]  MONTH_SEP     = 4'd9;
  localparam logic [MONTH_W-1:0]  MONTH_NOV     = 4'd11;

  // Leap check works on a 16-bit year: y / 25 = (y * LEAP_RECIP) >> LEAP_SHIFT
  // is exact for every y below 2^16.
  localparam int                  LEAP_YEAR_W = 16;
  localparam int                  LEAP_Q_W    = 12;
  localparam int                  LEAP_SHIFT  = 21;
  localparam logic [16:0]         LEAP_RECIP  = 17'd83887;

  typedef struct packed {
    logic                 cmd;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } in_word_t;

  typedef struct packed {
    logic [YEAR_OUT_W-1:0] year_now;
    logic [MONTH_W-1:0]    month_now;
    logic [DAY_W-1:0]      day_now;
    logic [HOUR_W-1:0]     hour_now;
    logic [MINUTE_W-1:0]   minute_now;
    logic [SECOND_W-1:0]   second_now;
    logic [MILLI_W-1:0]    milli_now;
    logic [TICK_W-1:0]     tick_total;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEAP_WAIT,
    ST_CARRY,
    ST_PUBLISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic carry_step;
    logic publish;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic carry_pending;
  } ctl_sts_t;

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
    logic [DAY_W-1:0] days;
    days = 5'd31;
    if (month == MONTH_APR || month == MONTH_JUN || month == MONTH_SEP ||
        month == MONTH_NOV) begin
      days = 5'd30;
    end else if (month == MONTH_FEB) begin
      days = leap ? 5'd29 : 5'd28;
    end
    return days;
  endfunction

endpackage

// ----- src/ccc_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the calendar clock counter: handshakes and carry loop control.
// Depends on ccc_pkg; drives ccc_datapath through ctl_cmd_t.
module ccc_ctrl import ccc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_LEAP_WAIT;
        end
      end
      ST_LEAP_WAIT: begin
        state_next = ST_CARRY;
      end
      ST_CARRY: begin
        if (sts.carry_pending) begin
          cmd.carry_step = 1'b1;
        end else begin
          state_next = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_accept_starts_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == ST_LEAP_WAIT)
    else $error("accepted word did not start the leap wait");

  a_rose_from_publish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_PUBLISH)
    else $error("result raised outside of publish");

  a_carry_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CARRY && !sts.carry_pending) |=> state == ST_PUBLISH)
    else $error("carry loop did not finish into publish");

endmodule

// ----- src/ccc_datapath.sv -----
`timescale 1ns / 1ps
// Counters, presets, leap-year pipeline and result register of the clock.
// Depends on ccc_pkg; sequenced by ccc_ctrl through ctl_cmd_t.
module ccc_datapath import ccc_pkg::*; #(
  parameter int MS_PER_TICK = 10,
  parameter int YEAR_BITS   = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  in_word_t               in_word,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  ctl_cmd_t               cmd,
  output ctl_sts_t               sts,
  output out_word_t              out_word
);

  localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;

  function automatic logic [YEAR_BITS-1:0] sat_year(input logic [YEAR_OUT_W-1:0] y);
    logic [YEAR_BITS-1:0] r;
    if (32'(y) > 32'(YEAR_MAX)) begin
      r = YEAR_MAX;
    end else begin
      r = YEAR_BITS'(y);
    end
    return r;
  endfunction

  // Preset registers
  logic [YEAR_OUT_W-1:0] preset_year,   preset_year_next;
  logic [MONTH_W-1:0]    preset_month,  preset_month_next;
  logic [DAY_W-1:0]      preset_day,    preset_day_next;
  logic [HOUR_W-1:0]     preset_hour,   preset_hour_next;
  logic [MINUTE_W-1:0]   preset_minute, preset_minute_next;
  logic                  preset_load;

  // Clock counters
  logic [MILLI_W-1:0]    milli_count;
  logic [SECOND_W-1:0]   second_count;
  logic [MINUTE_W-1:0]   minute_count;
  logic [HOUR_W-1:0]     hour_count;
  logic [DAY_W-1:0]      day_count;
  logic [MONTH_W-1:0]    month_count;
  logic [YEAR_BITS-1:0]  year_count;
  logic [TICK_W-1:0]     tick_count;
  logic [TOTAL_W-1:0]    total;

  // Leap pipeline
  logic [LEAP_YEAR_W-1:0] leap_year;
  logic [LEAP_Q_W-1:0]    leap_q;
  logic                   leap_flag;
  logic [LEAP_YEAR_W-1:0] year16;
  logic [33:0]            leap_prod;
  logic [LEAP_YEAR_W-1:0] q_times_25;
  logic [LEAP_YEAR_W-1:0] rem_25;

  // One-second step
  logic [6:0]            sec_inc, min_inc;
  logic [5:0]            hour_inc, day_inc;
  logic [DAY_W-1:0]      month_days;
  logic [SECOND_W-1:0]   second_step;
  logic [MINUTE_W-1:0]   minute_step;
  logic [HOUR_W-1:0]     hour_step;
  logic [DAY_W-1:0]      day_step;
  logic [MONTH_W-1:0]    month_step;
  logic [YEAR_BITS-1:0]  year_step;

  always_comb begin
    preset_year_next   = preset_year;
    preset_month_next  = preset_month;
    preset_day_next    = preset_day;
    preset_hour_next   = preset_hour;
    preset_minute_next = preset_minute;
    preset_load        = 1'b0;
    if (cfg_write) begin
      case (cfg_index)
        CFG_PRESET_YEAR: begin
          preset_year_next = cfg_data;
          preset_load      = 1'b1;
        end
        CFG_PRESET_MONTH: begin
          preset_month_next = cfg_data[MONTH_W-1:0];
          preset_load       = 1'b1;
        end
        CFG_PRESET_DAY: begin
          preset_day_next = cfg_data[DAY_W-1:0];
          preset_load     = 1'b1;
        end
        CFG_PRESET_HOUR: begin
          preset_hour_next = cfg_data[HOUR_W-1:0];
          preset_load      = 1'b1;
        end
        CFG_PRESET_MINUTE: begin
          preset_minute_next = cfg_data[MINUTE_W-1:0];
          preset_load        = 1'b1;
        end
        default: begin
          preset_load = 1'b0;
        end
      endcase
    end
  end

  // Leap year: divisible by 4, and not by 100 unless by 400.
  // Stage one divides by 25, stage two checks the remainder.
  assign year16     = LEAP_YEAR_W'(year_count);
  assign leap_prod  = 34'(year16) * 34'(LEAP_RECIP);
  assign q_times_25 = (LEAP_YEAR_W'(leap_q) << 4) + (LEAP_YEAR_W'(leap_q) << 3) +
                      LEAP_YEAR_W'(leap_q);
  assign rem_25     = leap_year - q_times_25;

  always_ff @(posedge clk) begin
    leap_year <= year16;
    leap_q    <= leap_prod[LEAP_SHIFT +: LEAP_Q_W];
    leap_flag <= (leap_year[1:0] == 2'b00) &&
                 ((rem_25 != '0) || (leap_year[3:0] == 4'b0000));
  end

  // Advance the calendar by one second, rippling as far as needed.
  always_comb begin
    sec_inc     = 7'(second_count) + 7'd1;
    min_inc     = 7'(minute_count) + 7'd1;
    hour_inc    = 6'(hour_count) + 6'd1;
    day_inc     = 6'(day_count) + 6'd1;
    month_days  = days_in_month(month_count, leap_flag);
    second_step = 6'(sec_inc);
    minute_step = minute_count;
    hour_step   = hour_count;
    day_step    = day_count;
    month_step  = month_count;
    year_step   = year_count;
    if (sec_inc >= SEC_PER_MIN) begin
      second_step = 6'(sec_inc - SEC_PER_MIN);
      minute_step = 6'(min_inc);
      if (min_inc >= MIN_PER_HOUR) begin
        minute_step = 6'(min_inc - MIN_PER_HOUR);
        hour_step   = 5'(hour_inc);
        if (hour_inc >= HOUR_PER_DAY) begin
          hour_step = 5'(hour_inc - HOUR_PER_DAY);
          day_step  = 5'(day_inc);
          if (day_inc > 6'(month_days)) begin
            day_step = 5'd1;
            if (month_count >= MONTH_LAST) begin
              month_step = 4'd1;
              if (year_count != YEAR_MAX) begin
                year_step = year_count + YEAR_BITS'(1);
              end
            end else begin
              month_step = month_count + 4'd1;
            end
          end
        end
      end
    end
  end

  assign sts.carry_pending = (total >= MS_PER_SEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      preset_year   <= RST_PRESET_YEAR;
      preset_month  <= RST_PRESET_MONTH;
      preset_day    <= RST_PRESET_DAY;
      preset_hour   <= RST_PRESET_HOUR;
      preset_minute <= RST_PRESET_MINUTE;
      milli_count   <= '0;
      second_count  <= '0;
      minute_count  <= RST_PRESET_MINUTE;
      hour_count    <= RST_PRESET_HOUR;
      day_count     <= RST_PRESET_DAY;
      month_count   <= RST_PRESET_MONTH;
      year_count    <= sat_year(RST_PRESET_YEAR);
      tick_count    <= '0;
    end else begin
      preset_year   <= preset_year_next;
      preset_month  <= preset_month_next;
      preset_day    <= preset_day_next;
      preset_hour   <= preset_hour_next;
      preset_minute <= preset_minute_next;
      if (preset_load) begin
        milli_count  <= '0;
        second_count <= '0;
        minute_count <= preset_minute_next;
        hour_count   <= preset_hour_next;
        day_count    <= preset_day_next;
        month_count  <= preset_month_next;
        year_count   <= sat_year(preset_year_next);
      end else if (cmd.carry_step) begin
        second_count <= second_step;
        minute_count <= minute_step;
        hour_count   <= hour_step;
        day_count    <= day_step;
        month_count  <= month_step;
        year_count   <= year_step;
      end else if (cmd.publish) begin
        milli_count <= total[MILLI_W-1:0];
      end
      if (cmd.accept && in_word.cmd == CMD_TICK) begin
        tick_count <= tick_count + TICK_W'(1);
      end
    end
  end

  // Pending milliseconds: loaded on accept, drained one second per step
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (in_word.cmd == CMD_ADVANCE) begin
        total <= TOTAL_W'(milli_count) + TOTAL_W'(in_word.elapsed_ms);
      end else begin
        total <= TOTAL_W'(milli_count) + TOTAL_W'(MS_PER_TICK);
      end
    end else if (cmd.carry_step) begin
      total <= total - MS_PER_SEC;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_word.year_now   <= YEAR_OUT_W'(year_count);
      out_word.month_now  <= month_count;
      out_word.day_now    <= day_count;
      out_word.hour_now   <= hour_count;
      out_word.minute_now <= minute_count;
      out_word.second_now <= second_count;
      out_word.milli_now  <= total[MILLI_W-1:0];
      out_word.tick_total <= tick_count;
    end
  end

  a_milli_in_range: assert property (@(posedge clk) disable iff (rst)
    milli_count < MILLI_W'(MS_PER_SEC))
    else $error("millisecond counter out of range");

  a_second_in_range: assert property (@(posedge clk) disable iff (rst)
    second_count < SECOND_W'(SEC_PER_MIN))
    else $error("second counter out of range");

  a_publish_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !sts.carry_pending)
    else $error("result published with a whole second still pending");

endmodule

// ----- src/calendar_clock_counter.sv -----
`timescale 1ns / 1ps
// Top level of the calendar clock counter: controller plus datapath.
// Depends on ccc_pkg, ccc_ctrl and ccc_datapath.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    in_word   (in_word_t: cmd, elapsed_ms)
//   out      out  out_valid / out_ready  out_word  (out_word_t: date, time, ticks)
//   cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An accepted word passes the leap wait, a carry step for each whole second it
// carries (0 to 5) and the publish step before its result is registered. The
// serial carry loop takes one word at a time; the next can be taken after publish.
// Reset loads the clock from the preset reset values and clears the tick count.
// The output register holds a finished result while the next word is accepted;
// a stalled result stalls only the publish step of the following word.
// Configuration writes are always taken; a write to a valid index reloads the clock.
module calendar_clock_counter import ccc_pkg::*; #(
  parameter int MS_PER_TICK = 10,
  parameter int YEAR_BITS   = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_word,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Configuration never stalls
  assign cfg_ready = 1'b1;

  // Sequence accept, leap settle, carry loop and publish
  ccc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the counters, presets and result word
  ccc_datapath #(
    .MS_PER_TICK (MS_PER_TICK),
    .YEAR_BITS   (YEAR_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_word  (out_word)
  );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for calendar_clock_counter: directed date checks, then random runs.
// Depends on ccc_pkg and the calendar_clock_counter RTL; needs nothing else.
module testbench;
  import ccc_pkg::*;

  localparam int TB_MS_PER_TICK = 10;
  localparam int TB_YEAR_BITS   = 14;
  localparam int unsigned YEAR_TOP = (1 << TB_YEAR_BITS) - 1;
  // Settling wait, used before a preset write and at the end
  localparam int SETTLE_CYCLES  = 8;
  localparam int QUIET_LIMIT    = 2000;
  localparam int RUN_ITEMS      = 420;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_word_t               in_word   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_word_t              out_word;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  calendar_clock_counter #(
    .MS_PER_TICK (TB_MS_PER_TICK),
    .YEAR_BITS   (TB_YEAR_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor: preset registers plus the running date and time
  // ---------------------------------------------------------------------------
  logic [YEAR_OUT_W-1:0] set_year;
  logic [MONTH_W-1:0]    set_month;
  logic [DAY_W-1:0]      set_day;
  logic [HOUR_W-1:0]     set_hour;
  logic [MINUTE_W-1:0]   set_minute;

  logic [YEAR_OUT_W-1:0] cal_year;
  logic [MONTH_W-1:0]    cal_month;
  logic [DAY_W-1:0]      cal_day;
  logic [HOUR_W-1:0]     cal_hour;
  logic [MINUTE_W-1:0]   cal_minute;
  logic [SECOND_W-1:0]   cal_second;
  logic [MILLI_W-1:0]    cal_milli;
  logic [TICK_W-1:0]     tick_seen;

  out_word_t expected_dates[$];
  out_word_t want_date;
  int        error_total = 0;
  int        items_sent  = 0;
  bit        src_idle    = 1'b1;
  bit        sink_idle   = 1'b1;
  int        sink_hold   = 0;
  int        sink_draw   = 0;
  int        quiet_cycles = 0;

  // Load the clock from the presets; the tick count survives a reload
  function automatic void reload_clock();
    cal_milli  = '0;
    cal_second = '0;
    cal_minute = set_minute;
    cal_hour   = set_hour;
    cal_day    = set_day;
    cal_month  = set_month;
    cal_year   = set_year;
  endfunction

  // Apply one preset write; an unknown index leaves everything alone
  function automatic void write_preset_model(input logic [CFG_INDEX_W-1:0] idx,
                                             input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_PRESET_YEAR:   set_year   = val[YEAR_OUT_W-1:0];
      CFG_PRESET_MONTH:  set_month  = val[MONTH_W-1:0];
      CFG_PRESET_DAY:    set_day    = val[DAY_W-1:0];
      CFG_PRESET_HOUR:   set_hour   = val[HOUR_W-1:0];
      CFG_PRESET_MINUTE: set_minute = val[MINUTE_W-1:0];
      default:           return;
    endcase
    reload_clock();
  endfunction

  // Ripple one second through minute, hour, day, month and year. Counters that
  // were preset out of range subtract their modulus once, so work in int.
  function automatic void carry_one_second();
    int unsigned nxt;
    int unsigned month_len;
    bit          leap;
    nxt = cal_second + 1;
    if (nxt < 60) begin
      cal_second = SECOND_W'(nxt);
      return;
    end
    cal_second = SECOND_W'(nxt - 60);
    nxt = cal_minute + 1;
    if (nxt < 60) begin
      cal_minute = MINUTE_W'(nxt);
      return;
    end
    cal_minute = MINUTE_W'(nxt - 60);
    nxt = cal_hour + 1;
    if (nxt < 24) begin
      cal_hour = HOUR_W'(nxt);
      return;
    end
    cal_hour = HOUR_W'(nxt - 24);
    // Full Gregorian leap rule on the saturated year
    leap = (cal_year % 4 == 0) && ((cal_year % 100 != 0) || (cal_year % 400 == 0));
    case (cal_month)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_len = 30;
      MONTH_FEB:                                  month_len = leap ? 29 : 28;
      default:                                    month_len = 31;
    endcase
    nxt = cal_day + 1;
    if (nxt <= month_len) begin
      cal_day = DAY_W'(nxt);
      return;
    end
    cal_day = DAY_W'(1);
    // Any month of 12 or more rolls into January; the year holds at its top
    if (cal_month >= MONTH_LAST) begin
      cal_month = MONTH_W'(1);
      if (cal_year < YEAR_TOP) cal_year = cal_year + YEAR_OUT_W'(1);
    end else begin
      cal_month = cal_month + MONTH_W'(1);
    end
  endfunction

  // Advance the calendar by one input word and return the date it reports
  function automatic out_word_t advance_calendar(input in_word_t w);
    int unsigned total;
    out_word_t   r;
    if (w.cmd == CMD_TICK) begin
      tick_seen = tick_seen + 1;
      total = cal_milli + TB_MS_PER_TICK;
    end else begin
      total = cal_milli + w.elapsed_ms;
    end
    while (total >= 1000) begin
      total = total - 1000;
      carry_one_second();
    end
    cal_milli    = MILLI_W'(total);
    r.year_now   = cal_year;
    r.month_now  = cal_month;
    r.day_now    = cal_day;
    r.hour_now   = cal_hour;
    r.minute_now = cal_minute;
    r.second_now = cal_second;
    r.milli_now  = cal_milli;
    r.tick_total = tick_seen;
    return r;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_total++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the field-by-field compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_hold <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_dates.size() == 0) begin
        $error("result word %h arrived with nothing expected", out_word);
        error_total++;
      end else begin
        want_date = expected_dates.pop_front();
        check_field("year_now",   want_date.year_now,   out_word.year_now);
        check_field("month_now",  want_date.month_now,  out_word.month_now);
        check_field("day_now",    want_date.day_now,    out_word.day_now);
        check_field("hour_now",   want_date.hour_now,   out_word.hour_now);
        check_field("minute_now", want_date.minute_now, out_word.minute_now);
        check_field("second_now", want_date.second_now, out_word.second_now);
        check_field("milli_now",  want_date.milli_now,  out_word.milli_now);
        check_field("tick_total", want_date.tick_total, out_word.tick_total);
      end
      // Draw the stall before the next word; keep ready high when it is zero
      sink_draw = sink_idle ? $urandom_range(0, 18) : 0;
      if (sink_draw != 0) begin
        out_ready <= 1'b0;
        sink_hold <= sink_draw - 1;
      end
    end else if (!out_ready) begin
      if (sink_hold == 0) out_ready <= 1'b1;
      else sink_hold <= sink_hold - 1;
    end
  end

  // Watchdog: end the run when no channel moves a word for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one word. Valid stays high after acceptance so a back-to-back word
  // never drops and raises it in the same step; drop it only before a gap.
  task automatic send_word(input logic cmd, input logic [ELAPSED_W-1:0] ms);
    int      gap;
    in_word_t w;
    gap = src_idle ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.cmd        = cmd;
    w.elapsed_ms = ms;
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_dates.push_back(advance_calendar(w));
    items_sent++;
  endtask

  // Hold the input channel and wait for every expected date to come back
  task automatic drain_dates();
    in_valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
  endtask

  // Write one preset register while the clock is idle
  task automatic write_preset(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    drain_dates();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    write_preset_model(idx, val);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Start from the reset date: ticks with junk in the ignored field, advances
  // of zero and of the largest step
  task automatic test_reset_date();
    send_word(CMD_TICK, '0);
    send_word(CMD_TICK, '1);
    send_word(CMD_ADVANCE, '0);
    send_word(CMD_ADVANCE, '1);
    send_word(CMD_ADVANCE, 12'd995);
  endtask

  // Write every preset, check the reload, then make sure an unknown index
  // neither reloads the clock nor clears the tick count
  task automatic test_preset_reload();
    write_preset(CFG_PRESET_YEAR,   14'd2000);
    write_preset(CFG_PRESET_MONTH,  14'd2);
    write_preset(CFG_PRESET_DAY,    14'd29);
    write_preset(CFG_PRESET_HOUR,   14'd23);
    write_preset(CFG_PRESET_MINUTE, 14'd59);
    send_word(CMD_ADVANCE, '1);
    write_preset(CFG_PRESET_MINUTE + 3'd1, '0);
    write_preset(3'd7, '1);
    send_word(CMD_ADVANCE, '1);
    send_word(CMD_TICK, 12'd7);
  endtask

  // Roll New Year's Eve at the top year: month wraps, year holds
  task automatic test_year_ceiling();
    write_preset(CFG_PRESET_YEAR,   '1);
    write_preset(CFG_PRESET_MONTH,  14'd12);
    write_preset(CFG_PRESET_DAY,    14'd31);
    write_preset(CFG_PRESET_HOUR,   14'd23);
    write_preset(CFG_PRESET_MINUTE, 14'd59);
    repeat (15) send_word(CMD_ADVANCE, '1);
  endtask

  // Random phases: presets biased toward rollovers, leap years and odd
  // out-of-range values, then a burst of ticks, random advances and large advances
  task automatic test_random_calendar();
    int                    burst;
    int                    roll;
    int unsigned           draw;
    logic [CFG_DATA_W-1:0] val;
    logic [ELAPSED_W-1:0]  ms;
    while (items_sent < RUN_ITEMS) begin
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 0) begin
        // Full preset set with values near the interesting edges
        for (int r = 0; r <= CFG_PRESET_MINUTE; r++) begin
          roll = $urandom_range(0, 7);
          case (r)
            CFG_PRESET_YEAR:
              case (roll)
                0: val = CFG_DATA_W'(0);
                1: val = CFG_DATA_W'(1900);
                2: val = CFG_DATA_W'(2000);
                3: val = CFG_DATA_W'(2100);
                4: val = CFG_DATA_W'(2024);
                5: val = CFG_DATA_W'(YEAR_TOP);
                6: val = CFG_DATA_W'(2400);
                default: val = CFG_DATA_W'($urandom_range(0, YEAR_TOP));
              endcase
            CFG_PRESET_MONTH:
              case (roll)
                0, 1: val = CFG_DATA_W'(MONTH_FEB);
                2: val = CFG_DATA_W'(MONTH_LAST);
                3: val = CFG_DATA_W'(0);
                4: val = CFG_DATA_W'($urandom_range(13, 15));
                default: val = CFG_DATA_W'($urandom_range(1, 12));
              endcase
            CFG_PRESET_DAY:
              case (roll)
                0, 1, 2: val = CFG_DATA_W'($urandom_range(28, 31));
                3: val = CFG_DATA_W'(0);
                default: val = CFG_DATA_W'($urandom_range(1, 31));
              endcase
            CFG_PRESET_HOUR:
              case (roll)
                0, 1, 2: val = CFG_DATA_W'(23);
                3: val = CFG_DATA_W'($urandom_range(24, 31));
                default: val = CFG_DATA_W'($urandom_range(0, 23));
              endcase
            default:
              case (roll)
                0, 1, 2: val = CFG_DATA_W'(59);
                3: val = CFG_DATA_W'($urandom_range(60, 63));
                default: val = CFG_DATA_W'($urandom_range(0, 59));
              endcase
          endcase
          write_preset(CFG_INDEX_W'(r), val);
        end
      end else begin
        // One or two raw writes: any index, any data bits
        repeat ($urandom_range(1, 2)) begin
          draw = $urandom;
          write_preset(CFG_INDEX_W'($urandom_range(0, 7)), draw[CFG_DATA_W-1:0]);
        end
      end
      burst = $urandom_range(10, 40);
      for (int n = 0; n < burst; n++) begin
        roll = $urandom_range(0, 9);
        draw = $urandom;
        ms   = draw[ELAPSED_W-1:0];
        if (roll < 3) send_word(CMD_TICK, ms);
        else if (roll < 6) send_word(CMD_ADVANCE, ms);
        else send_word(CMD_ADVANCE, ELAPSED_W'($urandom_range(3000, 4095)));
      end
      drain_dates();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    set_year   = RST_PRESET_YEAR;
    set_month  = RST_PRESET_MONTH;
    set_day    = RST_PRESET_DAY;
    set_hour   = RST_PRESET_HOUR;
    set_minute = RST_PRESET_MINUTE;
    tick_seen  = '0;
    reload_clock();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_date();
    test_preset_reload();
    test_year_ceiling();
    test_random_calendar();

    drain_dates();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (error_total == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
